FILE: sv/sva_pkg.sv
// Shared types and constants for the sample variance accumulator.
`default_nettype none

package sva_pkg;

    // Field and state widths.
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 20;
    localparam int FRAC_BITS   = 8;
    localparam int SUMSQ_W     = 51;
    localparam int SUM_W       = 37;
    localparam int CNT_W       = COUNT_BITS + 1;
    localparam int VAR_W       = 39;

    // Shared multiplier and finalise datapath widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NS_W   = CNT_W + SUMSQ_W;       // n * sum of squares
    localparam int ACC_W  = 2 * (SUM_W - 1) + 1;   // |sum| squared, up to 2^72
    localparam int DIFF_W = ACC_W;
    localparam int X_W    = DIFF_W + FRAC_BITS;    // scaled dividend
    localparam int DEN_W  = 2 * COUNT_BITS;        // n * (n - 1)
    localparam int ITER_W = $clog2(X_W);

    // Number of multiply steps in the finalise sequence.
    localparam int FIN_STEPS = 6;
    localparam int STEP_W    = $clog2(FIN_STEPS);

    // Input actions.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_MERGE = 2'd2,
        ACT_FINAL = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQ_WAIT,
        ST_ACCUM,
        ST_MUL,
        ST_DRAIN,
        ST_DIFF,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // Where a registered product goes.
    typedef enum logic [1:0] {
        DST_SQ,
        DST_NS,
        DST_MM,
        DST_DEN
    } t_dest;

    // Left shift applied to a product before it is accumulated.
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_33,
        SH_64
    } t_shift;

    // Control that travels alongside a product through the multiplier register.
    typedef struct packed {
        logic   vld;
        t_dest  dest;
        t_shift shift;
        logic   clr;
    } t_mul_ctl;

endpackage

`default_nettype wire

FILE: sv/sample_variance_accumulator_core.sv
// Top level of the streaming sample variance accumulator.
`default_nettype none

// The block keeps a sum of squares, a signed sum and a count, and takes one
// item at a time: o_ready is high only while the sequencer is idle. A clear
// or a null sample leaves the sequencer idle; a merge passes through the
// accumulate state, and a sample add through the square, square-wait and
// accumulate states. A finalise on fewer than two samples goes straight to
// the emit state. A finalise on two or more samples issues its multiply
// steps on the single shared 32 x 32 multiplier (n * S2, |S1|^2 and
// n * (n - 1), each product registered; the parts of n * S2 and |S1|^2 are
// accumulated and n * (n - 1) is stored as the divisor), then drains the
// product register, forms the difference, runs a restoring divider that
// retires one quotient bit per cycle, and loads the output register. A
// finished result is held in an output register, so the next item may be
// accepted while it waits to be taken; a finalise that finds that register
// still full waits until it is taken. An add or merge that would overflow
// the count or either sum is dropped and flagged on the next result.
module sample_variance_accumulator_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output      logic                                 o_ready,
    input  wire logic [1:0]                           i_action,
    input  wire logic signed [sva_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                 i_sample_null,
    input  wire logic [sva_pkg::SUMSQ_W-1:0]          i_partial_sum_sq,
    input  wire logic signed [sva_pkg::SUM_W-1:0]     i_partial_sum,
    input  wire logic [sva_pkg::CNT_W-1:0]            i_partial_count,
    output      logic                                 o_valid,
    input  wire logic                                 i_ready,
    output      logic [sva_pkg::VAR_W-1:0]            o_variance_q8,
    output      logic                                 o_result_null,
    output      logic                                 o_count_overflow
);

    localparam int SAMPLE_BITS = sva_pkg::SAMPLE_BITS;
    localparam int SUMSQ_W     = sva_pkg::SUMSQ_W;
    localparam int SUM_W       = sva_pkg::SUM_W;
    localparam int CNT_W       = sva_pkg::CNT_W;
    localparam int VAR_W       = sva_pkg::VAR_W;
    localparam int MUL_W       = sva_pkg::MUL_W;
    localparam int PROD_W      = sva_pkg::PROD_W;
    localparam int NS_W        = sva_pkg::NS_W;
    localparam int ACC_W       = sva_pkg::ACC_W;
    localparam int DIFF_W      = sva_pkg::DIFF_W;
    localparam int X_W         = sva_pkg::X_W;
    localparam int DEN_W       = sva_pkg::DEN_W;
    localparam int ITER_W      = sva_pkg::ITER_W;
    localparam int STEP_W      = sva_pkg::STEP_W;
    localparam int MAG_W       = SAMPLE_BITS + 1;

    localparam logic [CNT_W-1:0]  COUNT_LIMIT = CNT_W'(1) << sva_pkg::COUNT_BITS;
    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(sva_pkg::FIN_STEPS - 1);
    localparam logic [ITER_W-1:0] LAST_ITER   = ITER_W'(X_W - 1);

    // Architectural accumulator state.
    logic [SUMSQ_W-1:0] r_sq;
    logic [SUM_W-1:0]   r_s;
    logic [CNT_W-1:0]   r_n;
    logic               r_ovf_seen;

    // Operands of a pending add or merge.
    logic [SUMSQ_W-1:0] r_in_sq;
    logic [SUM_W-1:0]   r_in_s;
    logic [CNT_W-1:0]   r_in_n;

    // Finalise datapath.
    logic [SUM_W-1:0]   r_mag;
    logic [NS_W-1:0]    r_ns;
    logic [ACC_W-1:0]   r_mm;
    logic [DEN_W-1:0]   r_den;
    logic [X_W-1:0]     r_x;
    logic [DEN_W-1:0]   r_rem;
    logic [ITER_W-1:0]  r_iter;
    logic [STEP_W-1:0]  r_step;
    logic               r_res_null;
    logic               r_res_ovf;

    // Shared multiplier pipeline register.
    logic [PROD_W-1:0]  r_prod;
    sva_pkg::t_mul_ctl  r_ctl;

    // Output register.
    logic               r_out_valid;
    logic [VAR_W-1:0]   r_out_var;
    logic               r_out_null;
    logic               r_out_ovf;

    sva_pkg::t_state    r_state;
    sva_pkg::t_state    n_state;

    logic               in_xfer;
    logic               emit_go;
    sva_pkg::t_action   act;
    sva_pkg::t_mul_ctl  issue_ctl;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;

    assign act     = sva_pkg::t_action'(i_action);
    assign in_xfer = i_valid && o_ready;
    assign emit_go = !r_out_valid || i_ready;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sva_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    unique case (act)
                        sva_pkg::ACT_CLEAR: n_state = sva_pkg::ST_IDLE;
                        sva_pkg::ACT_ADD:
                            n_state = i_sample_null ? sva_pkg::ST_IDLE : sva_pkg::ST_SQUARE;
                        sva_pkg::ACT_MERGE: n_state = sva_pkg::ST_ACCUM;
                        sva_pkg::ACT_FINAL: begin
                            if (r_n > CNT_W'(1)) begin
                                n_state = sva_pkg::ST_MUL;
                            end else begin
                                n_state = sva_pkg::ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            sva_pkg::ST_SQUARE:  n_state = sva_pkg::ST_SQ_WAIT;
            sva_pkg::ST_SQ_WAIT: n_state = sva_pkg::ST_ACCUM;
            sva_pkg::ST_ACCUM:   n_state = sva_pkg::ST_IDLE;
            sva_pkg::ST_MUL: begin
                if (r_step == LAST_STEP) begin
                    n_state = sva_pkg::ST_DRAIN;
                end
            end
            sva_pkg::ST_DRAIN:   n_state = sva_pkg::ST_DIFF;
            sva_pkg::ST_DIFF:    n_state = sva_pkg::ST_DIVIDE;
            sva_pkg::ST_DIVIDE: begin
                if (r_iter == LAST_ITER) begin
                    n_state = sva_pkg::ST_EMIT;
                end
            end
            sva_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = sva_pkg::ST_IDLE;
                end
            end
            default: n_state = sva_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input handshake and multiplier issue.
    always_comb begin
        o_ready         = 1'b0;
        issue_ctl       = '0;
        issue_ctl.dest  = sva_pkg::DST_SQ;
        issue_ctl.shift = sva_pkg::SH_0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            sva_pkg::ST_IDLE: o_ready = 1'b1;
            sva_pkg::ST_SQUARE: begin
                issue_ctl.vld = 1'b1;
                issue_ctl.dest = sva_pkg::DST_SQ;
                mul_a = r_mag[MUL_W-1:0];
                mul_b = r_mag[MUL_W-1:0];
            end
            sva_pkg::ST_MUL: begin
                issue_ctl.vld = 1'b1;
                unique case (r_step)
                    STEP_W'(0): begin
                        issue_ctl.dest = sva_pkg::DST_NS;
                        issue_ctl.clr  = 1'b1;
                        mul_a = MUL_W'(r_n);
                        mul_b = r_sq[MUL_W-1:0];
                    end
                    STEP_W'(1): begin
                        issue_ctl.dest  = sva_pkg::DST_NS;
                        issue_ctl.shift = sva_pkg::SH_32;
                        mul_a = MUL_W'(r_n);
                        mul_b = MUL_W'(r_sq[SUMSQ_W-1:MUL_W]);
                    end
                    STEP_W'(2): begin
                        issue_ctl.dest = sva_pkg::DST_MM;
                        issue_ctl.clr  = 1'b1;
                        mul_a = r_mag[MUL_W-1:0];
                        mul_b = r_mag[MUL_W-1:0];
                    end
                    STEP_W'(3): begin
                        // Cross term counts twice, hence one extra bit of shift.
                        issue_ctl.dest  = sva_pkg::DST_MM;
                        issue_ctl.shift = sva_pkg::SH_33;
                        mul_a = r_mag[MUL_W-1:0];
                        mul_b = MUL_W'(r_mag[SUM_W-1:MUL_W]);
                    end
                    STEP_W'(4): begin
                        issue_ctl.dest  = sva_pkg::DST_MM;
                        issue_ctl.shift = sva_pkg::SH_64;
                        mul_a = MUL_W'(r_mag[SUM_W-1:MUL_W]);
                        mul_b = MUL_W'(r_mag[SUM_W-1:MUL_W]);
                    end
                    default: begin
                        issue_ctl.dest = sva_pkg::DST_DEN;
                        mul_a = MUL_W'(r_n);
                        mul_b = MUL_W'(r_n - CNT_W'(1));
                    end
                endcase
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier with its product register.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= issue_ctl;
        end
    end

    // Accumulation of registered products.
    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W-1:0] acc_sum;

    always_comb begin
        unique case (r_ctl.shift)
            sva_pkg::SH_0:  addend = ACC_W'(r_prod);
            sva_pkg::SH_32: addend = ACC_W'(r_prod) << 32;
            sva_pkg::SH_33: addend = ACC_W'(r_prod) << 33;
            sva_pkg::SH_64: addend = ACC_W'(r_prod) << 64;
            default:        addend = ACC_W'(r_prod);
        endcase
        if (r_ctl.clr) begin
            acc_base = '0;
        end else if (r_ctl.dest == sva_pkg::DST_NS) begin
            acc_base = ACC_W'(r_ns);
        end else begin
            acc_base = r_mm;
        end
        acc_sum = acc_base + addend;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.vld) begin
            unique case (r_ctl.dest)
                sva_pkg::DST_NS:  r_ns  <= acc_sum[NS_W-1:0];
                sva_pkg::DST_MM:  r_mm  <= acc_sum;
                sva_pkg::DST_DEN: r_den <= r_prod[DEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Candidate sums of an add or merge, with their range checks.
    logic [SUMSQ_W:0] new_sq;
    logic [SUM_W:0]   new_s;
    logic [CNT_W:0]   new_n;
    logic             acc_ovf;

    always_comb begin
        new_sq  = {1'b0, r_sq} + {1'b0, r_in_sq};
        new_s   = {r_s[SUM_W-1], r_s} + {r_in_s[SUM_W-1], r_in_s};
        new_n   = {1'b0, r_n} + {1'b0, r_in_n};
        acc_ovf = new_sq[SUMSQ_W] || (new_s[SUM_W] != new_s[SUM_W-1]) ||
                  (new_n > {1'b0, COUNT_LIMIT});
    end

    // Magnitudes of the incoming sample and of the running sum.
    logic [MAG_W-1:0] samp_ext;
    logic [MAG_W-1:0] samp_mag;
    logic [SUM_W-1:0] sum_mag;

    always_comb begin
        samp_ext = {i_sample[SAMPLE_BITS-1], i_sample};
        samp_mag = samp_ext[MAG_W-1] ? (MAG_W'(0) - samp_ext) : samp_ext;
        sum_mag  = r_s[SUM_W-1] ? (SUM_W'(0) - r_s) : r_s;
    end

    // Accumulator state and operand capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq       <= '0;
            r_s        <= '0;
            r_n        <= '0;
            r_ovf_seen <= 1'b0;
        end else if (in_xfer && act == sva_pkg::ACT_CLEAR) begin
            r_sq       <= '0;
            r_s        <= '0;
            r_n        <= '0;
            r_ovf_seen <= 1'b0;
        end else if (r_state == sva_pkg::ST_ACCUM) begin
            if (acc_ovf) begin
                r_ovf_seen <= 1'b1;
            end else begin
                r_sq <= new_sq[SUMSQ_W-1:0];
                r_s  <= new_s[SUM_W-1:0];
                r_n  <= new_n[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && act == sva_pkg::ACT_MERGE) begin
            r_in_sq <= i_partial_sum_sq;
            r_in_s  <= i_partial_sum;
            r_in_n  <= i_partial_count;
        end else if (in_xfer && act == sva_pkg::ACT_ADD) begin
            r_in_s  <= {{(SUM_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
            r_in_n  <= CNT_W'(1);
            r_mag   <= SUM_W'(samp_mag);
        end else if (r_ctl.vld && r_ctl.dest == sva_pkg::DST_SQ) begin
            r_in_sq <= r_prod[SUMSQ_W-1:0];
        end else if (in_xfer && act == sva_pkg::ACT_FINAL) begin
            r_mag   <= sum_mag;
        end
    end

    // Finalise flags, captured when the finalise item is taken.
    always_ff @(posedge i_clk) begin
        if (in_xfer && act == sva_pkg::ACT_FINAL) begin
            r_res_null <= (r_n == '0);
            r_res_ovf  <= r_ovf_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == sva_pkg::ST_MUL) begin
            r_step <= r_step + STEP_W'(1);
        end else begin
            r_step <= '0;
        end
    end

    // Magnitude of n * S2 - S1^2, both differences formed in parallel.
    logic [DIFF_W:0] d_mn;
    logic [DIFF_W:0] d_nm;
    logic [DIFF_W-1:0] diff;

    always_comb begin
        d_mn = {1'b0, r_mm} - (DIFF_W+1)'(r_ns);
        d_nm = (DIFF_W+1)'(r_ns) - {1'b0, r_mm};
        diff = d_mn[DIFF_W] ? d_nm[DIFF_W-1:0] : d_mn[DIFF_W-1:0];
    end

    // Restoring divider: one quotient bit per cycle, shifted into r_x.
    logic [DEN_W:0] rem_sh;
    logic           q_bit;
    logic [DEN_W:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_x[X_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && act == sva_pkg::ACT_FINAL) begin
            r_x <= '0;
        end else if (r_state == sva_pkg::ST_DIFF) begin
            r_x   <= {diff, {sva_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end else if (r_state == sva_pkg::ST_DIVIDE) begin
            r_x   <= {r_x[X_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (r_state == sva_pkg::ST_DIVIDE) begin
            r_iter <= r_iter + ITER_W'(1);
        end else begin
            r_iter <= '0;
        end
    end

    // Quotient saturated to the result width.
    logic [VAR_W-1:0] var_sat;

    assign var_sat = (|r_x[X_W-1:VAR_W]) ? {VAR_W{1'b1}} : r_x[VAR_W-1:0];

    // Output register: loaded when the result may move on, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == sva_pkg::ST_EMIT && emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sva_pkg::ST_EMIT && emit_go) begin
            r_out_var  <= var_sat;
            r_out_null <= r_res_null;
            r_out_ovf  <= r_res_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_variance_q8    = r_out_var;
    assign o_result_null    = r_out_null;
    assign o_count_overflow = r_out_ovf;

endmodule

`default_nettype wire
